[hw/rtl/dsh_pkg.sv]
// Shared constants and helpers for the diamond-square height map core.
package dsh_pkg;

   localparam int GRID_SIDE_DEFAULT = 129;

   localparam int PASS_COUNT_W = 4;
   localparam int START_RANGE_W = 24;
   localparam int DECAY_W = 16;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_INDEX_W = 2;

   localparam logic [PASS_COUNT_W-1:0] PASS_COUNT_RESET = 4'd6;
   localparam logic [START_RANGE_W-1:0] START_RANGE_RESET = 24'd3276800;
   localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd33924;

   localparam logic [CSR_INDEX_W-1:0] CSR_PASS_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_RANGE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY = 2'd2;

   localparam logic [1:0] MODE_SAMPLE = 2'd0;
   localparam logic [1:0] MODE_READ = 2'd1;
   localparam logic [1:0] MODE_RESTART = 2'd2;

   localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
   localparam logic signed [32:0] MIN_START = 33'sd655360000;

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      logic signed [31:0] r;
      if (v > 48'sd2147483647) r = 32'sh7fffffff;
      else if (v < -48'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

[hw/rtl/diamond_square_heightmap_core.sv]
// Diamond-square height map generator built around one shared multiplier.
//
// Channel  Direction  Beat contents
// req      in         tuser: mode; tdata: sample, row, column
// rsp      out        tuser: generation_done; tdata: height_value
// csr      in         write enable, register index, write data
//
// A sample beat reads its four neighbor positions in turn; a mean of one, two or four
// neighbors is formed directly and a mean of three takes a three-step divide by six.
// The last sample of a run adds a normalise sweep that finds the lowest point and then
// lifts every entry by its absolute value. After reset and after a restart beat the
// GRID_SIDE^2 entries (16641 by default) are cleared, one a cycle, with req_tready low.
// A read beat waits in ST_RD_OUT only while the previous response is held.
module diamond_square_heightmap_core #(
   parameter int GRID_SIDE = dsh_pkg::GRID_SIDE_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // sample[15:0], row[23:16], column[31:24]
   input  logic [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // height_value[31:0]
   output logic        rsp_tuser,   // generation_done[0]
   input  logic        csr_we,
   input  logic [dsh_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dsh_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import dsh_pkg::*;

   localparam int N = GRID_SIDE * GRID_SIDE;
   localparam int AW = $clog2(N);
   localparam int SW = AW + 1;
   localparam int CW = $clog2(3 * GRID_SIDE);
   localparam logic [CW-1:0] SIDE = CW'(GRID_SIDE);
   localparam logic [CW-1:0] SIDE_M1 = CW'(GRID_SIDE - 1);
   localparam logic [SW-1:0] N_S = SW'(N);
   localparam logic [AW-1:0] CORNER_1 = AW'(GRID_SIDE - 1);
   localparam logic [AW-1:0] CORNER_2 = AW'((GRID_SIDE - 1) * GRID_SIDE);
   localparam logic [AW-1:0] CORNER_3 = AW'(N - 1);
   // One sixth in Q0.16, exact for partial dividends below 2^15.
   localparam logic signed [16:0] DIV6_RECIP = 17'sd10923;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_NB_ISSUE, ST_NB_ACC, ST_MEAN, ST_DIV, ST_DISP,
      ST_WRITE, ST_ADV, ST_MIN, ST_ADD, ST_RD, ST_RD_OUT
   } state_type;

   function automatic logic [AW-1:0] grid_addr(input logic [31:0] r, input logic [31:0] c);
      logic [31:0] a;
      a = r * GRID_SIDE + c;
      return a[AW-1:0];
   endfunction

   logic [31:0] grid_mem [N];
   logic        mem_we;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [31:0] mem_wd;
   logic [31:0] mem_q_ff;

   state_type state_ff, state_in;
   logic [PASS_COUNT_W-1:0] pass_count_ff, pass_count_in;
   logic [START_RANGE_W-1:0] start_range_ff, start_range_in;
   logic [DECAY_W-1:0] decay_ff, decay_in;
   logic [PASS_COUNT_W-1:0] pass_ff, pass_in;
   logic [CW-1:0] rad_ff, rad_in, row_ff, row_in, col_ff, col_in;
   logic phase_ff, phase_in, parity_ff, parity_in, done_ff, done_in;
   logic [START_RANGE_W-1:0] range_ff, range_in;
   logic [SW-1:0] sweep_ff, sweep_in;
   logic rv_ff, rv_in;
   logic [AW-1:0] wa_ff, wa_in;
   logic [1:0] nb_ff, nb_in;
   logic nvalid_ff, nvalid_in, ningrid_ff, ningrid_in;
   logic signed [33:0] sum_ff, sum_in;
   logic [2:0] cnt_ff, cnt_in;
   logic signed [35:0] mean_ff, mean_in;
   logic [35:0] dm_ff, dm_in, dq_ff, dq_in;
   logic [2:0] drem_ff, drem_in;
   logic dneg_ff, dneg_in;
   logic [5:0] dcnt_ff, dcnt_in;
   logic signed [41:0] prod_ff, prod_in;
   logic signed [32:0] lo_ff, lo_in;
   logic signed [15:0] sample_ff, sample_in;
   logic rd_ok_ff, rd_ok_in;
   logic [31:0] rdata_ff, rdata_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_user_ff, rsp_user_in;
   logic [31:0] rsp_data_ff, rsp_data_in;

   // Shared multiplier: displacement in the write path, range decay when advancing,
   // and the twelve-bit digits of the divide by six.
   logic signed [24:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [41:0] mul_p;
   logic [14:0] dval;
   logic [11:0] dqd;
   assign dval = {drem_ff, dm_ff[35:24]};
   assign mul_a = (state_ff == ST_DIV) ? 25'(dval) : {1'b0, range_ff};
   assign mul_b = (state_ff == ST_ADV) ? $signed({1'b0, decay_ff})
                : (state_ff == ST_DIV) ? DIV6_RECIP
                                       : $signed({sample_ff[15], sample_ff});
   assign mul_p = mul_a * mul_b;
   assign dqd = mul_p[27:16];

   logic [CW-1:0] half, nr, nc, tr, tc;
   logic nvalid;
   logic [35:0] qnext;
   logic signed [35:0] num;
   logic signed [41:0] disp;
   logic signed [47:0] pt;
   logic [CW-1:0] col_step, row_step;
   logic [PASS_COUNT_W:0] pass_next, passes;
   logic [41:0] range_prod;
   logic signed [32:0] add_v;
   logic signed [32:0] q_ext;

   assign half = rad_ff >> 1;
   assign q_ext = {mem_q_ff[31], mem_q_ff};
   assign add_v = lo_ff[32] ? -lo_ff : lo_ff;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

   always_comb begin
      nr = row_ff;
      nc = col_ff;
      nvalid = 1'b1;
      case (nb_ff)
         2'd0: begin
            if (phase_ff) begin
               nr = row_ff - half;
               nvalid = (row_ff >= half);
            end
         end
         2'd1: begin
            if (phase_ff) begin
               nc = col_ff - half;
               nvalid = (col_ff >= half);
            end else begin
               nr = row_ff + rad_ff;
            end
         end
         2'd2: begin
            if (phase_ff) begin
               nr = row_ff + half;
               nvalid = (nr < SIDE);
            end else begin
               nc = col_ff + rad_ff;
            end
         end
         default: begin
            if (phase_ff) begin
               nc = col_ff + half;
               nvalid = (nc < SIDE);
            end else begin
               nr = row_ff + rad_ff;
               nc = col_ff + rad_ff;
            end
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      pass_count_in = pass_count_ff;
      start_range_in = start_range_ff;
      decay_in = decay_ff;
      pass_in = pass_ff;
      rad_in = rad_ff;
      row_in = row_ff;
      col_in = col_ff;
      phase_in = phase_ff;
      parity_in = parity_ff;
      done_in = done_ff;
      range_in = range_ff;
      sweep_in = sweep_ff;
      rv_in = rv_ff;
      wa_in = wa_ff;
      nb_in = nb_ff;
      nvalid_in = nvalid_ff;
      ningrid_in = ningrid_ff;
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      mean_in = mean_ff;
      dm_in = dm_ff;
      dq_in = dq_ff;
      drem_in = drem_ff;
      dneg_in = dneg_ff;
      dcnt_in = dcnt_ff;
      prod_in = prod_ff;
      lo_in = lo_ff;
      sample_in = sample_ff;
      rd_ok_in = rd_ok_ff;
      rdata_in = rdata_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      mem_we = 1'b0;
      mem_wa = sweep_ff[AW-1:0];
      mem_wd = 32'd0;
      mem_ra = sweep_ff[AW-1:0];
      qnext = {dq_ff[23:0], dqd};
      num = 36'sd0;
      disp = (prod_ff + 42'sd16384) >>> 15;
      pt = 48'(mean_ff) + 48'(disp);
      tr = phase_ff ? row_ff : row_ff + half;
      tc = phase_ff ? col_ff : col_ff + half;
      col_step = col_ff + rad_ff;
      row_step = row_ff + (phase_ff ? half : rad_ff);
      pass_next = {1'b0, pass_ff} + 1'b1;
      passes = (pass_count_ff == '0) ? 5'd1 : {1'b0, pass_count_ff};
      range_prod = 42'(mul_p) + 42'd32768;

      if (csr_we) begin
         unique case (csr_index)
            CSR_PASS_COUNT: pass_count_in = csr_wdata[PASS_COUNT_W-1:0];
            CSR_START_RANGE: start_range_in = csr_wdata[START_RANGE_W-1:0];
            CSR_DECAY: decay_in = csr_wdata[DECAY_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wd = (mem_wa == '0 || mem_wa == CORNER_1 || mem_wa == CORNER_2 ||
                      mem_wa == CORNER_3) ? ONE_Q16 : 32'd0;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == N_S - 1'b1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            mem_ra = grid_addr({24'd0, req_tdata[23:16]}, {24'd0, req_tdata[31:24]});
            if (req_tvalid) begin
               sample_in = req_tdata[15:0];
               case (req_tuser)
                  MODE_SAMPLE: begin
                     if (!done_ff) begin
                        nb_in = 2'd0;
                        sum_in = '0;
                        cnt_in = '0;
                        state_in = ST_NB_ISSUE;
                     end
                  end
                  MODE_READ: begin
                     rd_ok_in = (32'(req_tdata[23:16]) < GRID_SIDE) &&
                                (32'(req_tdata[31:24]) < GRID_SIDE);
                     state_in = ST_RD;
                  end
                  MODE_RESTART: begin
                     pass_in = '0;
                     rad_in = SIDE_M1;
                     phase_in = 1'b0;
                     row_in = '0;
                     col_in = '0;
                     parity_in = 1'b0;
                     range_in = start_range_ff;
                     done_in = 1'b0;
                     sweep_in = '0;
                     state_in = ST_CLEAR;
                  end
                  default: ;
               endcase
            end
         end
         ST_NB_ISSUE: begin
            mem_ra = grid_addr(32'(nr), 32'(nc));
            nvalid_in = nvalid;
            ningrid_in = (nr < SIDE) && (nc < SIDE);
            state_in = ST_NB_ACC;
         end
         ST_NB_ACC: begin
            if (nvalid_ff) begin
               sum_in = sum_ff + (ningrid_ff ? 34'(q_ext) : 34'sd0);
               cnt_in = cnt_ff + 1'b1;
            end
            nb_in = nb_ff + 1'b1;
            state_in = (nb_ff == 2'd3) ? ST_MEAN : ST_NB_ISSUE;
         end
         ST_MEAN: begin
            state_in = ST_DISP;
            case (cnt_ff)
               3'd4: mean_in = 36'((sum_ff + 34'sd2) >>> 2);
               3'd2: mean_in = 36'((sum_ff + 34'sd1) >>> 1);
               3'd3: begin
                  // Rounded mean of three is floor((2*sum+3)/6), done twelve bits a cycle.
                  num = (36'(sum_ff) <<< 1) + 36'sd3;
                  dneg_in = num[35];
                  dm_in = num[35] ? 36'(-num + 36'sd5) : 36'(num);
                  dq_in = '0;
                  drem_in = '0;
                  dcnt_in = 6'd3;
                  state_in = ST_DIV;
               end
               3'd1: mean_in = 36'(sum_ff);
               default: mean_in = '0;
            endcase
         end
         ST_DIV: begin
            drem_in = 3'(dval - 15'(dqd) * 15'd6);
            dm_in = dm_ff << 12;
            dq_in = qnext;
            dcnt_in = dcnt_ff - 1'b1;
            if (dcnt_ff == 6'd1) begin
               mean_in = dneg_ff ? -$signed(qnext) : $signed(qnext);
               state_in = ST_DISP;
            end
         end
         ST_DISP: begin
            prod_in = mul_p;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            mem_wa = grid_addr(32'(tr), 32'(tc));
            mem_wd = sat32(pt);
            mem_we = (tr < SIDE) && (tc < SIDE);
            state_in = ST_ADV;
         end
         ST_ADV: begin
            state_in = ST_IDLE;
            if (!phase_ff) begin
               col_in = col_step;
               if (col_step >= SIDE_M1) begin
                  col_in = '0;
                  row_in = row_step;
                  if (row_step >= SIDE_M1) begin
                     phase_in = 1'b1;
                     row_in = '0;
                     parity_in = 1'b0;
                     col_in = half;
                  end
               end
            end else if (col_step < SIDE) begin
               col_in = col_step;
            end else begin
               row_in = row_step;
               parity_in = ~parity_ff;
               col_in = parity_ff ? half : '0;
               if (row_step >= SIDE) begin
                  rad_in = half;
                  range_in = range_prod[16 +: START_RANGE_W];
                  phase_in = 1'b0;
                  row_in = '0;
                  col_in = '0;
                  parity_in = 1'b0;
                  if (half <= CW'(1)) begin
                     if (pass_next >= passes) begin
                        pass_in = pass_next[PASS_COUNT_W-1:0];
                        lo_in = MIN_START;
                        sweep_in = '0;
                        rv_in = 1'b0;
                        state_in = ST_MIN;
                     end else begin
                        pass_in = pass_next[PASS_COUNT_W-1:0];
                        rad_in = SIDE_M1;
                        range_in = start_range_ff;
                     end
                  end
               end
            end
         end
         ST_MIN: begin
            rv_in = (sweep_ff < N_S);
            if (sweep_ff < N_S) sweep_in = sweep_ff + 1'b1;
            if (rv_ff && q_ext < lo_ff) lo_in = q_ext;
            if (sweep_ff == N_S && !rv_ff) begin
               sweep_in = '0;
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            rv_in = (sweep_ff < N_S);
            wa_in = sweep_ff[AW-1:0];
            if (sweep_ff < N_S) sweep_in = sweep_ff + 1'b1;
            mem_wa = wa_ff;
            mem_wd = sat32(48'(q_ext) + 48'(add_v));
            mem_we = rv_ff;
            if (sweep_ff == N_S && !rv_ff) begin
               done_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_RD: begin
            rdata_in = rd_ok_ff ? mem_q_ff : 32'd0;
            state_in = ST_RD_OUT;
         end
         ST_RD_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = rdata_ff;
               rsp_user_in = done_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) grid_mem[mem_wa] <= mem_wd;
      mem_q_ff <= grid_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         pass_count_ff <= PASS_COUNT_RESET;
         start_range_ff <= START_RANGE_RESET;
         decay_ff <= DECAY_RESET;
         pass_ff <= '0;
         rad_ff <= SIDE_M1;
         row_ff <= '0;
         col_ff <= '0;
         phase_ff <= 1'b0;
         parity_ff <= 1'b0;
         done_ff <= 1'b0;
         range_ff <= START_RANGE_RESET;
         sweep_ff <= '0;
         rv_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass_count_ff <= pass_count_in;
         start_range_ff <= start_range_in;
         decay_ff <= decay_in;
         pass_ff <= pass_in;
         rad_ff <= rad_in;
         row_ff <= row_in;
         col_ff <= col_in;
         phase_ff <= phase_in;
         parity_ff <= parity_in;
         done_ff <= done_in;
         range_ff <= range_in;
         sweep_ff <= sweep_in;
         rv_ff <= rv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wa_ff <= wa_in;
      nb_ff <= nb_in;
      nvalid_ff <= nvalid_in;
      ningrid_ff <= ningrid_in;
      sum_ff <= sum_in;
      cnt_ff <= cnt_in;
      mean_ff <= mean_in;
      dm_ff <= dm_in;
      dq_ff <= dq_in;
      drem_ff <= drem_in;
      dneg_ff <= dneg_in;
      dcnt_ff <= dcnt_in;
      prod_ff <= prod_in;
      lo_ff <= lo_in;
      sample_ff <= sample_in;
      rd_ok_ff <= rd_ok_in;
      rdata_ff <= rdata_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

[tb/diamond_square_heightmap_core_checker.sv]
// Height map predictor and response checker for the diamond-square core.
module diamond_square_heightmap_core_checker #(
   parameter int GRID_SIDE = dsh_pkg::GRID_SIDE_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        csr_we,
   input  logic [dsh_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dsh_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int          fail_count,
   output int          heights_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import dsh_pkg::*;

   localparam int CELLS = GRID_SIDE * GRID_SIDE;

   typedef struct {
      logic [31:0] height;
      logic        done;
   } height_read_type;

   height_read_type expected_heights[$];

   logic signed [31:0] height_map[0:CELLS-1];
   int          passes_done;
   int          radius;
   logic        square_step;
   int          cur_row;
   int          cur_col;
   logic        odd_row;
   longint      range_q16;
   logic        map_done;
   logic [PASS_COUNT_W-1:0]  cfg_passes;
   logic [START_RANGE_W-1:0] cfg_start;
   logic [DECAY_W-1:0]       cfg_decay;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic longint sat(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint div_floor(input longint a, input longint d);
      longint q;
      q = a / d;
      if ((a % d) != 0 && a < 0) q--;
      return q;
   endfunction

   function automatic longint height_at(input longint r, input longint c);
      if (r < 0 || c < 0 || r >= GRID_SIDE || c >= GRID_SIDE) return 0;
      return longint'(height_map[r * GRID_SIDE + c]);
   endfunction

   task automatic store_height(input longint r, input longint c, input longint v);
      if (r < 0 || c < 0 || r >= GRID_SIDE || c >= GRID_SIDE) return;
      height_map[r * GRID_SIDE + c] = 32'(sat(v));
   endtask

   task automatic clear_map();
      for (int k = 0; k < CELLS; k++) height_map[k] = '0;
      height_map[0] = ONE_Q16;
      height_map[GRID_SIDE - 1] = ONE_Q16;
      height_map[(GRID_SIDE - 1) * GRID_SIDE] = ONE_Q16;
      height_map[CELLS - 1] = ONE_Q16;
      passes_done = 0;
      radius = GRID_SIDE - 1;
      square_step = 1'b0;
      cur_row = 0;
      cur_col = 0;
      odd_row = 1'b0;
      range_q16 = longint'(cfg_start);
      map_done = 1'b0;
   endtask

   // Lift the whole map by the absolute value of its lowest point.
   task automatic lift_map();
      longint lowest;
      longint offset;
      lowest = longint'(MIN_START);
      for (int k = 0; k < CELLS; k++)
         if (longint'(height_map[k]) < lowest) lowest = longint'(height_map[k]);
      offset = lowest < 0 ? -lowest : lowest;
      for (int k = 0; k < CELLS; k++)
         height_map[k] = 32'(sat(longint'(height_map[k]) + offset));
   endtask

   task automatic displace_point(input longint s);
      longint half;
      longint sum;
      longint count;
      longint mean;
      longint disp;
      half = radius / 2;
      sum = 0;
      count = 0;
      if (!square_step) begin
         sum = height_at(cur_row, cur_col) + height_at(cur_row + radius, cur_col)
             + height_at(cur_row, cur_col + radius)
             + height_at(cur_row + radius, cur_col + radius);
         count = 4;
      end else begin
         if (cur_row >= half) begin sum += height_at(cur_row - half, cur_col); count++; end
         if (cur_col >= half) begin sum += height_at(cur_row, cur_col - half); count++; end
         if (cur_row + half < GRID_SIDE) begin
            sum += height_at(cur_row + half, cur_col); count++;
         end
         if (cur_col + half < GRID_SIDE) begin
            sum += height_at(cur_row, cur_col + half); count++;
         end
      end
      mean = count != 0 ? div_floor(2 * sum + count, 2 * count) : 0;
      disp = div_floor(s * range_q16 + 16384, 32768);
      if (!square_step) store_height(cur_row + half, cur_col + half, mean + disp);
      else store_height(cur_row, cur_col, mean + disp);
   endtask

   task automatic step_cursor();
      int half;
      int passes;
      half = radius / 2;
      passes = cfg_passes != 0 ? int'(cfg_passes) : 1;
      if (!square_step) begin
         cur_col += radius;
         if (cur_col >= GRID_SIDE - 1) begin
            cur_col = 0;
            cur_row += radius;
            if (cur_row >= GRID_SIDE - 1) begin
               square_step = 1'b1;
               cur_row = 0;
               odd_row = 1'b0;
               cur_col = half;
            end
         end
         return;
      end
      cur_col += radius;
      if (cur_col < GRID_SIDE) return;
      cur_row += half;
      odd_row = ~odd_row;
      cur_col = odd_row ? 0 : half;
      if (cur_row < GRID_SIDE) return;
      radius = radius / 2;
      range_q16 = (range_q16 * longint'(cfg_decay) + 32768) >>> 16;
      square_step = 1'b0;
      cur_row = 0;
      cur_col = 0;
      odd_row = 1'b0;
      if (radius > 1) return;
      passes_done++;
      if (passes_done >= passes) begin
         passes_done = passes_done & 15;
         lift_map();
         map_done = 1'b1;
      end else begin
         radius = GRID_SIDE - 1;
         range_q16 = longint'(cfg_start);
      end
   endtask

   always @(posedge clock) begin
      height_read_type want;
      logic [7:0] r;
      logic [7:0] c;
      if (reset) begin
         fail_count = 0;
         cfg_passes = PASS_COUNT_RESET;
         cfg_start = START_RANGE_RESET;
         cfg_decay = DECAY_RESET;
         clear_map();
         expected_heights.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PASS_COUNT:  cfg_passes = csr_wdata[PASS_COUNT_W-1:0];
               CSR_START_RANGE: cfg_start = csr_wdata[START_RANGE_W-1:0];
               CSR_DECAY:       cfg_decay = csr_wdata[DECAY_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_heights.size() == 0) begin
               report("unexpected response beat", rsp_tdata, '0);
            end else begin
               want = expected_heights.pop_front();
               if (rsp_tdata !== want.height) report("height_value", rsp_tdata, want.height);
               if (rsp_tuser !== want.done)
                  report("generation_done", 32'(rsp_tuser), 32'(want.done));
            end
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               MODE_SAMPLE: begin
                  if (!map_done) begin
                     displace_point(longint'(signed'(req_tdata[15:0])));
                     step_cursor();
                  end
               end
               MODE_READ: begin
                  r = req_tdata[23:16];
                  c = req_tdata[31:24];
                  want.height = '0;
                  if (r < GRID_SIDE && c < GRID_SIDE) want.height = height_map[r * GRID_SIDE + c];
                  want.done = map_done;
                  expected_heights.push_back(want);
               end
               MODE_RESTART: clear_map();
               default: ;
            endcase
         end
      end
      heights_pending = expected_heights.size();
   end
endmodule

[tb/diamond_square_heightmap_core_tb.sv]
// Stimulus and verdict for the diamond-square height map core.
module diamond_square_heightmap_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dsh_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // sample[15:0], row[23:16], column[31:24]
   logic [1:0]  req_tuser;   // mode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // height_value[31:0]
   logic        rsp_tuser;   // generation_done[0]
   logic        csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int          fail_count;
   int          heights_pending;
   int          sender_idle_pct;
   int          receiver_idle_pct;

   diamond_square_heightmap_core u_top (.*);

   diamond_square_heightmap_core_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);

   initial begin
      #50ms;
      $display("diamond_square_heightmap_core verification failed");
      $finish;
   end

   // Holds one beat on the request channel until the core takes it.
   task automatic send_beat(input logic [1:0] mode, input logic [15:0] s,
                            input logic [7:0] r, input logic [7:0] c);
      logic taken;
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {c, r, s};
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic random_beat(input int restart_pct);
      int pick;
      pick = $urandom_range(99);
      if (pick < restart_pct)
         send_beat(MODE_RESTART, 16'($urandom), 8'($urandom), 8'($urandom));
      else if (pick < 35)
         send_beat(MODE_READ, 16'($urandom), 8'($urandom_range(0, 140)), 8'($urandom));
      else if (pick < 38)
         send_beat(MODE_UNUSED, 16'($urandom), 8'($urandom), 8'($urandom));
      else
         send_beat(MODE_SAMPLE, 16'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // A read beat cannot pass while the grid is being cleared, so its response marks idle.
   task automatic settle();
      send_beat(MODE_READ, '0, 8'd64, 8'd64);
      req_tvalid <= 1'b0;
      while (heights_pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int guard;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = MODE_SAMPLE;
      csr_we = 1'b0;
      csr_index = CSR_PASS_COUNT;
      csr_wdata = '0;
      sender_idle_pct = 21;
      receiver_idle_pct = 50;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Corners, center, reads outside the grid, the extreme samples, an unused mode and a restart.
      send_beat(MODE_READ, '0, 8'd0, 8'd0);
      send_beat(MODE_READ, '0, 8'd0, 8'd128);
      send_beat(MODE_READ, '0, 8'd128, 8'd0);
      send_beat(MODE_READ, '0, 8'd128, 8'd128);
      send_beat(MODE_READ, '0, 8'd129, 8'd0);
      send_beat(MODE_READ, '0, 8'd0, 8'd255);
      send_beat(MODE_READ, 16'hffff, 8'd255, 8'd255);
      send_beat(MODE_SAMPLE, 16'h7fff, 8'hff, 8'hff);
      send_beat(MODE_SAMPLE, 16'h8000, 8'd0, 8'd0);
      send_beat(MODE_SAMPLE, 16'h0000, 8'd0, 8'd0);
      send_beat(MODE_SAMPLE, 16'hffff, 8'd0, 8'd0);
      send_beat(MODE_SAMPLE, 16'h0001, 8'd0, 8'd0);
      send_beat(MODE_READ, '0, 8'd64, 8'd64);
      send_beat(MODE_READ, '0, 8'd0, 8'd64);
      send_beat(MODE_UNUSED, 16'hffff, 8'hff, 8'hff);
      send_beat(MODE_READ, '0, 8'd64, 8'd0);
      send_beat(MODE_RESTART, '0, 8'd0, 8'd0);
      send_beat(MODE_READ, '0, 8'd64, 8'd64);
      send_beat(MODE_READ, '0, 8'd128, 8'd128);
      settle();

      write_reg(CSR_PASS_COUNT, CSR_DATA_W'(1));
      write_reg(CSR_START_RANGE, 24'hffffff);
      write_reg(CSR_DECAY, CSR_DATA_W'(16'hffff));
      send_beat(MODE_RESTART, '0, 8'd0, 8'd0);
      repeat (300) random_beat(2);
      settle();

      sender_idle_pct = 50;
      receiver_idle_pct = 21;
      write_reg(CSR_PASS_COUNT, CSR_DATA_W'(15));
      write_reg(CSR_START_RANGE, '0);
      write_reg(CSR_DECAY, '0);
      repeat (300) random_beat(2);
      settle();

      // A single-pass run with the default range and decay, then a random mix.
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      write_reg(CSR_PASS_COUNT, '0);
      write_reg(CSR_START_RANGE, START_RANGE_RESET);
      write_reg(CSR_DECAY, CSR_DATA_W'(DECAY_RESET));
      send_beat(MODE_RESTART, '0, 8'd0, 8'd0);
      for (int k = 0; k < 100; k++) begin
         if ($urandom_range(19) == 0)
            send_beat(MODE_READ, '0, 8'($urandom_range(0, 128)), 8'($urandom_range(0, 128)));
         else
            send_beat(MODE_SAMPLE, 16'($urandom), 8'($urandom), 8'($urandom));
      end
      repeat (80) random_beat(0);
      req_tvalid <= 1'b0;

      guard = 0;
      while (heights_pending != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (200) @(posedge clock);
      if (fail_count == 0 && heights_pending == 0) begin
         $display("diamond_square_heightmap_core verification clean");
      end else begin
         $display("diamond_square_heightmap_core verification failed");
      end
      $finish;
   end
endmodule

[diamond_square_heightmap_core.f]
hw/rtl/dsh_pkg.sv
hw/rtl/diamond_square_heightmap_core.sv
tb/diamond_square_heightmap_core_checker.sv
tb/diamond_square_heightmap_core_tb.sv
